// ----- rtl/qvd_pkg.sv -----
// ----------------------------------------------------------------------------
// qvd_pkg
// Shared types and constants of the quantized vector distance unit.
// ----------------------------------------------------------------------------
package qvd_pkg;

	localparam int QVD_QUEUE_DEPTH = 8;
	localparam int CFG_IDX_W       = 3;

	// load value of the range split step counter after a register write
	localparam logic [1:0]  SPLIT_LOAD = 2'd3;
	// floor(x / 255) = (x * RECIP_255) >> 39 for every 32-bit x
	localparam logic [31:0] RECIP_255  = 32'h8080_8081;
	localparam logic [15:0] CODE_HALF  = 16'd127;

	localparam logic MODE_DOT = 1'b0;
	localparam logic MODE_L2  = 1'b1;

	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 3'd0,
		REG_MIN   = 3'd1,
		REG_MAX   = 3'd2,
		REG_SCALE = 3'd3,
		REG_QSUM  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_ACC,
		BK_M0,
		BK_M1,
		BK_M2,
		BK_M3,
		BK_SAT
	} bk_state_t;

	// Register values and the derived range split: range = 255 * rng_quo + rng_rem
	typedef struct packed {
		logic               mode;
		logic signed [31:0] min_value;
		logic signed [31:0] dot_scale;
		logic signed [31:0] query_sum;
		logic               rng_pos;
		logic [24:0]        rng_quo;
		logic [7:0]         rng_rem;
		logic               busy;
	} cfg_t;

	// One per-pair term handed from the front part to the back part
	typedef struct packed {
		logic signed [63:0] term;
		logic               last;
		logic               mode;
	} entry_t;

endpackage

// ----- rtl/qvd_cfg.sv -----
// ----------------------------------------------------------------------------
// qvd_cfg
// Configuration registers and a reciprocal multiply that splits the
// quantization range into a multiple of 255 and a remainder.
// ----------------------------------------------------------------------------
module qvd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [qvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output qvd_pkg::cfg_t                  cfg
);

	logic               mode_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic signed [31:0] scale_q;
	logic signed [31:0] qsum_q;
	logic [1:0]         cnt_q;
	logic [31:0]        rng_q;
	logic [24:0]        quo_q;
	logic [7:0]         rem_q;
	logic               pos_q;

	logic               wr;
	logic [32:0]        rng;
	logic [63:0]        prod_c;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign rng       = {max_q[31], max_q} - {min_q[31], min_q};
	assign prod_c    = 64'(rng_q) * 64'(qvd_pkg::RECIP_255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= qvd_pkg::MODE_DOT;
			min_q   <= '0;
			max_q   <= '0;
			scale_q <= '0;
			qsum_q  <= '0;
			cnt_q   <= '0;
			rng_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			pos_q   <= 1'b0;
		end else if (wr) begin
			case (qvd_pkg::cfg_reg_t'(cfg_index))
				qvd_pkg::REG_MODE:  mode_q  <= cfg_data[0];
				qvd_pkg::REG_MIN:   min_q   <= cfg_data;
				qvd_pkg::REG_MAX:   max_q   <= cfg_data;
				qvd_pkg::REG_SCALE: scale_q <= cfg_data;
				qvd_pkg::REG_QSUM:  qsum_q  <= cfg_data;
				default: ;
			endcase
			// restart the split so it always matches the newest registers
			cnt_q <= qvd_pkg::SPLIT_LOAD;
		end else if (cnt_q == qvd_pkg::SPLIT_LOAD) begin
			pos_q <= !rng[32] && (|rng[31:0]);
			rng_q <= rng[31:0];
			cnt_q <= cnt_q - 2'd1;
		end else if (cnt_q == 2'd2) begin
			quo_q <= prod_c[63:39];
			cnt_q <= cnt_q - 2'd1;
		end else if (cnt_q != '0) begin
			// range + quotient = 256 * quotient + remainder
			rem_q <= rng_q[7:0] + quo_q[7:0];
			cnt_q <= cnt_q - 2'd1;
		end
	end

	assign cfg.mode      = mode_q;
	assign cfg.min_value = min_q;
	assign cfg.dot_scale = scale_q;
	assign cfg.query_sum = qsum_q;
	assign cfg.rng_pos   = pos_q;
	assign cfg.rng_quo   = quo_q;
	assign cfg.rng_rem   = rem_q;
	assign cfg.busy      = cnt_q != '0;

endmodule

// ----- rtl/qvd_front.sv -----
// ----------------------------------------------------------------------------
// qvd_front
// Accepts element pairs and turns each into its accumulator term in a
// four-stage pipeline: dot product or dequantized squared difference.
// ----------------------------------------------------------------------------
module qvd_front #(
	parameter int Depth = qvd_pkg::QVD_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,
	input  logic                          s_axis_tlast,
	input  qvd_pkg::cfg_t                 cfg,
	input  logic [$clog2(Depth+1)-1:0]    q_count,
	output logic                          push,
	output qvd_pkg::entry_t               push_entry
);

	localparam int OCC_W = $clog2(Depth + 5);

	logic v_s1, v_s2, v_s3, v_s4;

	logic [15:0]        q_s1, q_s2;
	logic [7:0]         code_s1;
	logic               last_s1, last_s2, last_s3;
	logic               mode_s1, mode_s2, mode_s3;
	logic signed [24:0] dot_s2, dot_s3;
	logic [32:0]        off_s2;
	logic [31:0]        mag_s3;
	logic               big_s3;
	qvd_pkg::entry_t    entry_s4;

	logic [OCC_W-1:0]   occ;
	logic               accept;
	logic signed [24:0] dot_c;
	logic [31:0]        coarse_c;
	logic [15:0]        small_c;
	logic [15:0]        fine_sum_c;
	logic [32:0]        off_c;
	logic [34:0]        d_c;
	logic [34:0]        mag_c;
	logic [63:0]        sq_c;
	logic signed [63:0] term_c;

	// reserve a queue slot for every item in flight
	assign occ = OCC_W'(q_count) + OCC_W'(v_s1) + OCC_W'(v_s2) + OCC_W'(v_s3)
		+ OCC_W'(v_s4);
	assign s_axis_tready = !cfg.busy && (occ < OCC_W'(Depth));
	assign accept        = s_axis_tvalid && s_axis_tready;

	// floor((code*range + 127) / 255) = code*quo + floor((code*rem + 127) / 255)
	assign dot_c      = $signed(q_s1) * $signed({1'b0, code_s1});
	assign coarse_c   = 32'(code_s1) * 32'(cfg.rng_quo);
	assign small_c    = 16'(code_s1) * 16'(cfg.rng_rem) + qvd_pkg::CODE_HALF;
	assign fine_sum_c = small_c + 16'd1 + (small_c >> 8);
	assign off_c      = cfg.rng_pos ? 33'(coarse_c) + 33'(fine_sum_c[15:8]) : '0;

	assign d_c   = {{11{q_s2[15]}}, q_s2, 8'h00} - {{3{cfg.min_value[31]}}, cfg.min_value}
		- {2'b00, off_s2};
	assign mag_c = d_c[34] ? 35'(-d_c) : d_c;

	assign sq_c = 64'(mag_s3) * 64'(mag_s3);

	always_comb begin
		if (mode_s3 == qvd_pkg::MODE_L2) begin
			if (big_s3 || sq_c[63]) begin
				term_c = qvd_pkg::ACC_MAX;
			end else begin
				term_c = $signed(sq_c);
			end
		end else begin
			term_c = {{39{dot_s3[24]}}, dot_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		q_s1    <= s_axis_tdata[15:0];
		code_s1 <= s_axis_tdata[23:16];
		last_s1 <= s_axis_tlast;
		mode_s1 <= cfg.mode;

		q_s2    <= q_s1;
		dot_s2  <= dot_c;
		off_s2  <= off_c;
		last_s2 <= last_s1;
		mode_s2 <= mode_s1;

		mag_s3  <= mag_c[31:0];
		big_s3  <= |mag_c[34:32];
		dot_s3  <= dot_s2;
		last_s3 <= last_s2;
		mode_s3 <= mode_s2;

		entry_s4.term <= term_c;
		entry_s4.last <= last_s3;
		entry_s4.mode <= mode_s3;
	end

	assign push       = v_s4;
	assign push_entry = entry_s4;

endmodule

// ----- rtl/qvd_queue.sv -----
// ----------------------------------------------------------------------------
// qvd_queue
// Short FIFO of terms between the front and back parts.
// ----------------------------------------------------------------------------
module qvd_queue #(
	parameter int Depth = qvd_pkg::QVD_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  qvd_pkg::entry_t               push_entry,
	input  logic                          pop,
	output logic                          head_valid,
	output qvd_pkg::entry_t               head,
	output logic [$clog2(Depth+1)-1:0]    count
);

	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	qvd_pkg::entry_t slots [Depth];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign head_valid = count_q != '0;
	assign head       = slots[rd_ptr_q];
	assign count      = count_q;

endmodule

// ----- rtl/qvd_back.sv -----
// ----------------------------------------------------------------------------
// qvd_back
// Saturating accumulator and final stage. Dot results run through a shared
// 33x32 multiplier in three products and saturate to Q31.32.
// ----------------------------------------------------------------------------
module qvd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  qvd_pkg::entry_t  head,
	output logic             pop,
	input  qvd_pkg::cfg_t    cfg,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [63:0]      m_axis_tdata
);

	qvd_pkg::bk_state_t state_q, state_d;

	logic signed [63:0] acc_q;
	logic signed [64:0] prod_q;
	logic signed [95:0] wide_q;
	logic               out_valid_q;
	logic [63:0]        out_data_q;

	logic [64:0]        sum_c;
	logic signed [63:0] acc_next;
	logic               out_free;
	logic               ld_acc, clr_acc, ld_out_l2, ld_out_dot;
	logic signed [32:0] a_op;
	logic signed [31:0] b_op;
	logic               in_rng;
	logic [63:0]        sat_c;

	assign sum_c = {acc_q[63], acc_q} + {head.term[63], head.term};
	always_comb begin
		if (sum_c[64] != sum_c[63]) begin
			acc_next = sum_c[64] ? qvd_pkg::ACC_MIN : qvd_pkg::ACC_MAX;
		end else begin
			acc_next = $signed(sum_c[63:0]);
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		ld_acc     = 1'b0;
		clr_acc    = 1'b0;
		ld_out_l2  = 1'b0;
		ld_out_dot = 1'b0;
		case (state_q)
			qvd_pkg::BK_ACC: begin
				if (head_valid) begin
					if (!head.last) begin
						pop    = 1'b1;
						ld_acc = 1'b1;
					end else if (head.mode == qvd_pkg::MODE_L2) begin
						if (out_free) begin
							pop       = 1'b1;
							ld_out_l2 = 1'b1;
							clr_acc   = 1'b1;
						end
					end else begin
						pop     = 1'b1;
						ld_acc  = 1'b1;
						state_d = qvd_pkg::BK_M0;
					end
				end
			end
			qvd_pkg::BK_M0: state_d = qvd_pkg::BK_M1;
			qvd_pkg::BK_M1: state_d = qvd_pkg::BK_M2;
			qvd_pkg::BK_M2: state_d = qvd_pkg::BK_M3;
			qvd_pkg::BK_M3: state_d = qvd_pkg::BK_SAT;
			qvd_pkg::BK_SAT: begin
				// hold the finished value until the output register frees up
				if (out_free) begin
					ld_out_dot = 1'b1;
					clr_acc    = 1'b1;
					state_d    = qvd_pkg::BK_ACC;
				end
			end
			default: state_d = qvd_pkg::BK_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qvd_pkg::BK_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// acc * scale = acc_hi * scale * 2^32 + acc_lo * scale, then + query_sum * min
	always_comb begin
		case (state_q)
			qvd_pkg::BK_M0: begin
				a_op = $signed({1'b0, acc_q[31:0]});
				b_op = cfg.dot_scale;
			end
			qvd_pkg::BK_M1: begin
				a_op = {acc_q[63], acc_q[63:32]};
				b_op = cfg.dot_scale;
			end
			default: begin
				a_op = {cfg.query_sum[31], cfg.query_sum};
				b_op = cfg.min_value;
			end
		endcase
	end

	assign in_rng = (&wide_q[95:55]) || !(|wide_q[95:55]);
	assign sat_c  = in_rng ? {wide_q[55:0], 8'h00}
		: (wide_q[95] ? qvd_pkg::ACC_MIN : qvd_pkg::ACC_MAX);

	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
		case (state_q)
			qvd_pkg::BK_M1: wide_q <= {{31{prod_q[64]}}, prod_q};
			qvd_pkg::BK_M2: wide_q <= wide_q + $signed({prod_q[63:0], 32'h0});
			qvd_pkg::BK_M3: wide_q <= wide_q + $signed({{31{prod_q[64]}}, prod_q});
			default: ;
		endcase
		if (ld_out_l2) begin
			out_data_q <= acc_next;
		end else if (ld_out_dot) begin
			out_data_q <= sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_acc) begin
				acc_q <= '0;
			end else if (ld_acc) begin
				acc_q <= acc_next;
			end
			if (ld_out_l2 || ld_out_dot) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/quantized_vector_distance_unit.sv -----
// ----------------------------------------------------------------------------
// quantized_vector_distance_unit
// Streams query elements against 8-bit codes and emits a dot value or a
// squared Euclidean distance in Q31.32 at the end of each vector.
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | payload
// s_axis   | in        | s_axis_tvalid/tready   | tdata: query_elem, code_byte; tlast
// m_axis   | out       | m_axis_tvalid/tready   | tdata: distance
// cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One pair per cycle unless the input stalls; the term pipeline is four stages deep.
// A vector ends when its last term enters the output register in squared-distance
// mode; in dot mode the sum first passes BK_M0 to BK_M3 (three products on one
// 33x32 multiplier) and BK_SAT. After each register write the input stalls
// while the range is split by 255 with a reciprocal multiply.
// Reset clears registers, accumulator, queue and output valid; input stalls when
// the term queue is full, the back part stalls on the output register.
// ----------------------------------------------------------------------------
module quantized_vector_distance_unit #(
	parameter int QueueDepth = qvd_pkg::QVD_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,   // [15:0] query_elem, [23:16] code_byte
	input  logic                          s_axis_tlast,   // last_elem
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [63:0]                   m_axis_tdata,   // [63:0] distance
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qvd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	qvd_pkg::cfg_t                      cfg;
	logic                               push;
	qvd_pkg::entry_t                    push_entry;
	logic                               pop;
	logic                               head_valid;
	qvd_pkg::entry_t                    head;
	logic [$clog2(QueueDepth+1)-1:0]    q_count;

	qvd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qvd_front #(
		.Depth (QueueDepth)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cfg           (cfg),
		.q_count       (q_count),
		.push          (push),
		.push_entry    (push_entry)
	);

	qvd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	qvd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.cfg           (cfg),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- rtl/qvd_chk.sv -----
// ----------------------------------------------------------------------------
// qvd_chk
// Port-level checks of the quantized vector distance unit.
// ----------------------------------------------------------------------------
module qvd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [23:0]                   s_axis_tdata,
	input logic                          s_axis_tlast,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [63:0]                   m_axis_tdata,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [qvd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a register write blocks input while the range split restarts
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_axis_tready)
		else $error("item input open right after a register write");

	// input is still closed in the last step of the range split
	a_cfg_split: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> ##3 !s_axis_tready)
		else $error("item input opened before the range split finished");

endmodule

bind quantized_vector_distance_unit qvd_chk u_chk (.*);
